/* hdl/acu_pkg.sv */
// ----------------------------------------------------------------------------
// acu_pkg
// Shared types, instruction codes and sizing constants of the accumulator ALU
// control unit.
// ----------------------------------------------------------------------------
`default_nettype none

package acu_pkg;

    // default size of the byte data store
    localparam int MEM_DEPTH_DEF = 2048;

    // field widths fixed by the instruction word
    localparam int ACTION_W = 5;
    localparam int BYTE_W   = 8;
    localparam int ADDR_W   = 11;
    localparam int ACC_W    = 32;
    localparam int STATUS_W = 2;

    // conditional-subtract steps for the address wrap; the smallest store
    // (16 entries) leaves a quotient below 2**7
    localparam int MOD_STEPS = 7;

    // decoupling queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // instruction codes
    localparam logic [ACTION_W-1:0] CODE_WM   = 5'h01;
    localparam logic [ACTION_W-1:0] CODE_RM   = 5'h02;
    localparam logic [ACTION_W-1:0] CODE_WB   = 5'h06;
    localparam logic [ACTION_W-1:0] CODE_WACC = 5'h09;
    localparam logic [ACTION_W-1:0] CODE_RACC = 5'h0B;
    localparam logic [ACTION_W-1:0] CODE_SHR  = 5'h15;
    localparam logic [ACTION_W-1:0] CODE_SHL  = 5'h16;
    localparam logic [ACTION_W-1:0] CODE_XOR  = 5'h17;
    localparam logic [ACTION_W-1:0] CODE_NOT  = 5'h18;
    localparam logic [ACTION_W-1:0] CODE_OR   = 5'h19;
    localparam logic [ACTION_W-1:0] CODE_AND  = 5'h1A;
    localparam logic [ACTION_W-1:0] CODE_MUL  = 5'h1B;
    localparam logic [ACTION_W-1:0] CODE_BAD  = 5'h1C;
    localparam logic [ACTION_W-1:0] CODE_SUB  = 5'h1D;
    localparam logic [ACTION_W-1:0] CODE_ADD  = 5'h1E;
    localparam logic [ACTION_W-1:0] CODE_EOP  = 5'h1F;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EOP     = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_INVALID = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_IGNORED = 2'd3;

    // decoded operation class
    typedef enum logic [4:0] {
        OP_NOP,
        OP_WM,
        OP_RM,
        OP_WB,
        OP_WACC,
        OP_RACC,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_AND,
        OP_OR,
        OP_NOT,
        OP_XOR,
        OP_SHL,
        OP_SHR,
        OP_INVALID,
        OP_EOP
    } op_e;

    // input word
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                preload_mbr;
        logic [BYTE_W-1:0]   mbr_value;
        logic [ADDR_W-1:0]   address;
    } in_word_t;

    // result word
    typedef struct packed {
        logic signed [ACC_W-1:0] acc_value;
        logic [BYTE_W-1:0]       mbr_out;
        logic                    zero_flag;
        logic                    carry_flag;
        logic                    sign_flag;
        logic                    overflow_flag;
        logic [STATUS_W-1:0]     status;
    } out_word_t;

    // classified command held in the queue; address already wrapped
    typedef struct packed {
        op_e               op;
        logic              preload;
        logic [BYTE_W-1:0] mbr_value;
        logic [ADDR_W-1:0] address;
    } cmd_t;

endpackage

`default_nettype wire

/* hdl/accumulator_alu_control_unit_top.sv */
// ----------------------------------------------------------------------------
// accumulator_alu_control_unit_top
// Accumulator machine with 32-bit wrapping accumulator, bus and buffer
// registers, flags, byte data store and an 8x8 Booth multiplier.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake            word type
//   s_        in          s_valid / s_ready    acu_pkg::in_word_t
//   m_        out         m_valid / m_ready    acu_pkg::out_word_t
//
// one word per clock sustained while m_ready stays high, one result per instruction word
// a result passes from its queue entry through the execute slot and the
// output register to m_valid; the execute stage, with its eight dependent
// Booth add/shift steps, sets the clock period
// aresetn clears the registers, flags and halt state; the data store is not
// cleared and holds garbage until written
// a stalled m_ready fills the output register, the execute slot and the
// two-entry queue, after which s_ready drops
// ----------------------------------------------------------------------------
`default_nettype none

module accumulator_alu_control_unit_top #(
    parameter int MEM_DEPTH = acu_pkg::MEM_DEPTH_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  acu_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output acu_pkg::out_word_t m_data
);

    // classified command from the front decode
    acu_pkg::cmd_t front_cmd;
    // head of the queue towards execute
    acu_pkg::cmd_t q_cmd;
    logic          q_valid;
    logic          q_ready;

    // front: decode and address wrap, purely combinational
    acu_front #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_front (
        .in_word (s_data),
        .cmd     (front_cmd)
    );

    // queue decouples acceptance from execution
    acu_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_valid),
        .push_ready (s_ready),
        .push_data  (front_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_cmd)
    );

    // back: execute, data store and result register
    acu_back #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

/* hdl/acu_front.sv */
// ----------------------------------------------------------------------------
// acu_front
// Decodes the instruction code into an operation class and wraps the address
// into the data store range.
// ----------------------------------------------------------------------------
`default_nettype none

module acu_front #(
    parameter int MEM_DEPTH = acu_pkg::MEM_DEPTH_DEF
) (
    input  acu_pkg::in_word_t in_word,
    output acu_pkg::cmd_t     cmd
);

    acu_pkg::op_e                   op;
    logic [acu_pkg::ADDR_W-1:0]     addr_wrapped;

    always_comb begin
        case (in_word.action)
            acu_pkg::CODE_WM:   op = acu_pkg::OP_WM;
            acu_pkg::CODE_RM:   op = acu_pkg::OP_RM;
            acu_pkg::CODE_WB:   op = acu_pkg::OP_WB;
            acu_pkg::CODE_WACC: op = acu_pkg::OP_WACC;
            acu_pkg::CODE_RACC: op = acu_pkg::OP_RACC;
            acu_pkg::CODE_SHR:  op = acu_pkg::OP_SHR;
            acu_pkg::CODE_SHL:  op = acu_pkg::OP_SHL;
            acu_pkg::CODE_XOR:  op = acu_pkg::OP_XOR;
            acu_pkg::CODE_NOT:  op = acu_pkg::OP_NOT;
            acu_pkg::CODE_OR:   op = acu_pkg::OP_OR;
            acu_pkg::CODE_AND:  op = acu_pkg::OP_AND;
            acu_pkg::CODE_MUL:  op = acu_pkg::OP_MUL;
            acu_pkg::CODE_BAD:  op = acu_pkg::OP_INVALID;
            acu_pkg::CODE_SUB:  op = acu_pkg::OP_SUB;
            acu_pkg::CODE_ADD:  op = acu_pkg::OP_ADD;
            acu_pkg::CODE_EOP:  op = acu_pkg::OP_EOP;
            default:            op = acu_pkg::OP_NOP;
        endcase
    end

    // address modulo store depth by restoring conditional subtraction
    always_comb begin
        logic [31:0] rem;
        logic [31:0] dv;
        rem = 32'(in_word.address);
        dv  = '0;
        for (int k = acu_pkg::MOD_STEPS - 1; k >= 0; k--) begin
            dv = 32'(MEM_DEPTH) << k;
            if (rem >= dv) begin
                rem = rem - dv;
            end
        end
        addr_wrapped = rem[acu_pkg::ADDR_W-1:0];
    end

    assign cmd.op        = op;
    assign cmd.preload   = in_word.preload_mbr;
    assign cmd.mbr_value = in_word.mbr_value;
    assign cmd.address   = addr_wrapped;

endmodule

`default_nettype wire

/* hdl/acu_queue.sv */
// ----------------------------------------------------------------------------
// acu_queue
// Short command queue between the front decode and the back execute stage.
// ----------------------------------------------------------------------------
`default_nettype none

module acu_queue (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push_valid,
    output logic             push_ready,
    input  acu_pkg::cmd_t    push_data,
    output logic             pop_valid,
    input  wire logic        pop_ready,
    output acu_pkg::cmd_t    pop_data
);

    acu_pkg::cmd_t                 entry_reg [acu_pkg::QUEUE_DEPTH];
    logic [acu_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [acu_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [acu_pkg::QCNT_W-1:0]    count_reg, count_next;
    logic                          do_push, do_pop;

    assign push_ready = (count_reg != acu_pkg::QCNT_W'(acu_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* hdl/acu_back.sv */
// ----------------------------------------------------------------------------
// acu_back
// Execute stage: architectural registers, byte data store, ALU with Booth
// multiplier and the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module acu_back #(
    parameter int MEM_DEPTH = acu_pkg::MEM_DEPTH_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    input  acu_pkg::cmd_t      cmd,
    output logic               m_valid,
    input  wire logic          m_ready,
    output acu_pkg::out_word_t m_data
);

    localparam int MAW = $clog2(MEM_DEPTH);

    typedef struct packed {
        logic z;
        logic c;
        logic s;
        logic o;
    } flags_t;

    function automatic logic [15:0] booth8(input logic [7:0] mcand,
                                           input logic [7:0] mplier);
        logic [7:0] a;
        logic [7:0] q;
        logic       qm;
        a  = '0;
        q  = mplier;
        qm = 1'b0;
        for (int i = 0; i < 8; i++) begin
            case ({q[0], qm})
                2'b10:   a = a - mcand;
                2'b01:   a = a + mcand;
                default: a = a;
            endcase
            qm = q[0];
            q  = {a[0], q[7:1]};
            a  = {a[7], a[7:1]};
        end
        return {a, q};
    endfunction

    function automatic flags_t calc_flags(input logic [acu_pkg::ACC_W-1:0] r);
        flags_t f;
        f.z = (r == '0);
        f.s = r[7];
        f.c = !r[31] && (r[30:8] != '0);
        f.o = !r[31] && (r[30:7] != '0);
        return f;
    endfunction

    logic [acu_pkg::BYTE_W-1:0] mem [MEM_DEPTH];

    // architectural state
    logic [acu_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic [acu_pkg::BYTE_W-1:0] bus_reg, bus_next;
    logic [acu_pkg::BYTE_W-1:0] mbr_reg, mbr_next;
    flags_t                     flags_reg, flags_next;
    logic                       halted_reg, halted_next;

    // execute slot
    logic                       x_valid_reg;
    acu_pkg::cmd_t              x_cmd_reg;
    logic [acu_pkg::BYTE_W-1:0] rdata_reg;
    logic                       fwd_reg;
    logic [acu_pkg::BYTE_W-1:0] fwd_data_reg;

    // output register
    logic                       m_valid_reg;
    acu_pkg::out_word_t         m_data_reg;

    logic                        retire, load_x, mem_we;
    logic [acu_pkg::BYTE_W-1:0]  mbr_pre, rd_byte;
    logic [acu_pkg::ACC_W-1:0]   alu_res;
    logic                        alu_en;
    logic [acu_pkg::STATUS_W-1:0] status;

    assign retire    = x_valid_reg && (!m_valid_reg || m_ready);
    assign load_x    = cmd_valid && (!x_valid_reg || retire);
    assign cmd_ready = !x_valid_reg || retire;
    assign rd_byte   = fwd_reg ? fwd_data_reg : rdata_reg;
    assign mbr_pre   = x_cmd_reg.preload ? x_cmd_reg.mbr_value : mbr_reg;

    always_comb begin
        acc_next    = acc_reg;
        bus_next    = bus_reg;
        mbr_next    = mbr_reg;
        flags_next  = flags_reg;
        halted_next = halted_reg;
        alu_res     = acc_reg;
        alu_en      = 1'b0;
        mem_we      = 1'b0;
        status      = acu_pkg::STAT_DONE;
        if (halted_reg) begin
            status = acu_pkg::STAT_IGNORED;
        end else begin
            mbr_next = mbr_pre;
            case (x_cmd_reg.op)
                acu_pkg::OP_WM:   mem_we = 1'b1;
                acu_pkg::OP_RM:   mbr_next = rd_byte;
                acu_pkg::OP_WB:   bus_next = mbr_pre;
                acu_pkg::OP_WACC: acc_next = acu_pkg::ACC_W'(mbr_pre);
                acu_pkg::OP_RACC: mbr_next = acc_reg[7:0];
                acu_pkg::OP_ADD: begin
                    alu_res = acc_reg + acu_pkg::ACC_W'(bus_reg);
                    alu_en  = 1'b1;
                end
                acu_pkg::OP_SUB: begin
                    alu_res = acc_reg - acu_pkg::ACC_W'(bus_reg);
                    alu_en  = 1'b1;
                end
                acu_pkg::OP_MUL: begin
                    alu_res = acu_pkg::ACC_W'(booth8(acc_reg[7:0], bus_reg));
                    alu_en  = 1'b1;
                end
                acu_pkg::OP_AND: begin
                    alu_res = acc_reg & acu_pkg::ACC_W'(bus_reg);
                    alu_en  = 1'b1;
                end
                acu_pkg::OP_OR: begin
                    alu_res = acc_reg | acu_pkg::ACC_W'(bus_reg);
                    alu_en  = 1'b1;
                end
                acu_pkg::OP_NOT: begin
                    alu_res = ~acc_reg;
                    alu_en  = 1'b1;
                end
                acu_pkg::OP_XOR: begin
                    alu_res = acc_reg ^ acu_pkg::ACC_W'(bus_reg);
                    alu_en  = 1'b1;
                end
                acu_pkg::OP_SHL: begin
                    alu_res = {acc_reg[acu_pkg::ACC_W-2:0], 1'b0};
                    alu_en  = 1'b1;
                end
                acu_pkg::OP_SHR: begin
                    alu_res = acu_pkg::ACC_W'(acc_reg[7:1]);
                    alu_en  = 1'b1;
                end
                acu_pkg::OP_INVALID: begin
                    halted_next = 1'b1;
                    status      = acu_pkg::STAT_INVALID;
                end
                acu_pkg::OP_EOP: begin
                    halted_next = 1'b1;
                    status      = acu_pkg::STAT_EOP;
                end
                default: ;
            endcase
            if (alu_en) begin
                acc_next   = alu_res;
                flags_next = calc_flags(alu_res);
            end
        end
    end

    // control and architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            bus_reg     <= '0;
            mbr_reg     <= '0;
            flags_reg   <= '0;
            halted_reg  <= 1'b0;
            x_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (retire) begin
                acc_reg    <= acc_next;
                bus_reg    <= bus_next;
                mbr_reg    <= mbr_next;
                flags_reg  <= flags_next;
                halted_reg <= halted_next;
            end
            if (load_x) begin
                x_valid_reg <= 1'b1;
            end else if (retire) begin
                x_valid_reg <= 1'b0;
            end
            if (retire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers; a store to the address being read is forwarded
    always_ff @(posedge aclk) begin
        if (load_x) begin
            x_cmd_reg    <= cmd;
            rdata_reg    <= mem[MAW'(cmd.address)];
            fwd_reg      <= retire && mem_we && (x_cmd_reg.address == cmd.address);
            fwd_data_reg <= mbr_pre;
        end
        if (retire && mem_we) begin
            mem[MAW'(x_cmd_reg.address)] <= mbr_pre;
        end
        if (retire) begin
            m_data_reg.acc_value     <= acc_next;
            m_data_reg.mbr_out       <= mbr_next;
            m_data_reg.zero_flag     <= flags_next.z;
            m_data_reg.carry_flag    <= flags_next.c;
            m_data_reg.sign_flag     <= flags_next.s;
            m_data_reg.overflow_flag <= flags_next.o;
            m_data_reg.status        <= status;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

/* hdl/acu_checker.sv */
// ----------------------------------------------------------------------------
// acu_checker
// Port-level checks of the accumulator ALU control unit, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module acu_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input acu_pkg::in_word_t       s_data,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input acu_pkg::out_word_t      m_data
);

    // set once a halting word has been delivered
    logic seen_halt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_halt_reg <= 1'b0;
        end else if (m_valid && m_ready &&
                     (m_data.status == acu_pkg::STAT_EOP ||
                      m_data.status == acu_pkg::STAT_INVALID)) begin
            seen_halt_reg <= 1'b1;
        end
    end

    // a waiting input word does not change
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input word changed while waiting");

    // a held result word does not change
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // words are ignored exactly once a halt has been delivered
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (seen_halt_reg == (m_data.status == acu_pkg::STAT_IGNORED)))
        else $error("ignored status does not follow halt");

    // flag consistency: zero excludes the others, carry implies overflow
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_data.zero_flag ||
                     (!m_data.sign_flag && !m_data.carry_flag &&
                      !m_data.overflow_flag)) &&
                    (!m_data.carry_flag || m_data.overflow_flag))
        else $error("inconsistent flags");

    // no result straight out of reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind accumulator_alu_control_unit_top acu_checker u_acu_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
